>>> src/ngp_pkg.sv
// shared types, constants and byte-level helpers for the nmea position parser
// no dependencies
package ngp_pkg;

	localparam int LineBytes  = 256;
	localparam int LenW       = $clog2(LineBytes);
	localparam int FieldSlots = 12;
	localparam int SlotW      = $clog2(FieldSlots);
	localparam int FldW       = 5;

	localparam logic [FldW-1:0] FldMax = 5'd31;
	localparam logic [23:0] DegCap     = 24'd9999999;
	localparam logic [29:0] Recip6     = 30'd715827883;
	localparam logic [31:0] LatLim     = 32'd900000000;
	localparam logic [31:0] LonLim     = 32'd1800000000;
	localparam logic [19:0] TimeoutRst = 20'd2000;

	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] Ch0      = 8'h30;
	localparam logic [7:0] Ch9      = 8'h39;
	localparam logic [7:0] ChA      = 8'h41;
	localparam logic [7:0] ChC      = 8'h43;
	localparam logic [7:0] ChG      = 8'h47;
	localparam logic [7:0] ChM      = 8'h4D;
	localparam logic [7:0] ChR      = 8'h52;
	localparam logic [7:0] ChS      = 8'h53;
	localparam logic [7:0] ChV      = 8'h56;
	localparam logic [7:0] ChW      = 8'h57;

	// event codes double as the reported sentence kind
	typedef enum logic [1:0] {
		EvGga  = 2'd0,
		EvRmc  = 2'd1,
		EvTick = 2'd2,
		EvNone = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		PhSign = 2'd0,
		PhInt  = 2'd1,
		PhFrac = 2'd2,
		PhStop = 2'd3
	} phase_t;

	// number accumulator: integer part kept as ipart/100 and two decimal digits
	typedef struct packed {
		logic        nonempty;
		logic [7:0]  first;
		phase_t      phase;
		logic        neg;
		logic [23:0] deg;
		logic [3:0]  tens;
		logic [3:0]  ones;
		logic [16:0] frac;
		logic [2:0]  fdig;
	} acc_t;

	typedef struct packed {
		ev_t         kind;
		logic        set_fix;
		logic        clr_fix;
		logic        set_pos;
		logic        set_alt;
		logic        set_sat;
		logic [7:0]  sat;
		logic [20:0] alt;
		logic [13:0] hdop;
		logic [31:0] lat_degp;
		logic [23:0] lat_q;
		logic        lat_neg;
		logic [31:0] lon_degp;
		logic [23:0] lon_q;
		logic        lon_neg;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        fix;
		logic        fresh;
		logic [30:0] lat;
		logic [31:0] lon;
		logic [20:0] alt;
		logic [13:0] hdop;
		logic [7:0]  sat;
	} rep_t;

	function automatic logic [16:0] frac_weight(input logic [3:0] d, input logic [2:0] k);
		logic [16:0] w;
		unique case (k)
			3'd0:    w = 17'(d) * 17'd10000;
			3'd1:    w = 17'(d) * 17'd1000;
			3'd2:    w = 17'(d) * 17'd100;
			3'd3:    w = 17'(d) * 17'd10;
			default: w = 17'(d);
		endcase
		return w;
	endfunction

	function automatic acc_t acc_feed(input acc_t a, input logic [7:0] c);
		acc_t        r;
		logic        digit;
		logic [27:0] deg_w;
		r     = a;
		digit = (c >= Ch0) && (c <= Ch9);
		deg_w = 28'(a.deg) * 28'd10 + 28'(a.tens);
		if (!a.nonempty) begin
			r.nonempty = 1'b1;
			r.first    = c;
		end
		priority if (a.phase == PhSign && (c == ChPlus || c == ChMinus)) begin
			r.neg   = (c == ChMinus);
			r.phase = PhInt;
		end else if ((a.phase == PhSign || a.phase == PhInt) && digit) begin
			r.phase = PhInt;
			if (deg_w > 28'(DegCap)) begin
				r.deg  = DegCap;
				r.tens = 4'd9;
				r.ones = 4'd9;
			end else begin
				r.deg  = deg_w[23:0];
				r.tens = a.ones;
				r.ones = c[3:0];
			end
		end else if ((a.phase == PhSign || a.phase == PhInt) && c == ChDot) begin
			r.phase = PhFrac;
		end else if (a.phase == PhFrac && digit) begin
			if (a.fdig < 3'd5) begin
				r.frac = a.frac + frac_weight(c[3:0], a.fdig);
				r.fdig = a.fdig + 3'd1;
			end
		end else begin
			r.phase = PhStop;
		end
		return r;
	endfunction

endpackage

>>> src/ngp_line.sv
// line framing, sentence type detection and per-field number accumulators
// depends on ngp_pkg
module ngp_line import ngp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       s1_valid,
	input  logic       s1_op,
	input  logic [7:0] s1_byte,
	output ev_t        ev,
	output acc_t       acc [FieldSlots]
);

	logic [LenW-1:0] len_q;
	logic            dollar_q;
	logic [FldW-1:0] fld_q;
	logic [15:0]     recent_q;
	logic            gga_q;
	logic            rmc_q;
	acc_t            acc_q [FieldSlots];

	logic clear;
	logic step;

	always_comb begin
		ev    = EvNone;
		clear = 1'b0;
		step  = 1'b0;
		if (s1_valid) begin
			if (s1_op) begin
				ev = EvTick;
			end else if (s1_byte == ChLf || s1_byte == ChCr) begin
				if (len_q != '0) begin
					clear = 1'b1;
					if (dollar_q && gga_q) begin
						ev = EvGga;
					end else if (dollar_q && rmc_q) begin
						ev = EvRmc;
					end
				end
			end else if (len_q < LenW'(LineBytes - 1)) begin
				step = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			dollar_q <= 1'b0;
			fld_q    <= '0;
			recent_q <= '0;
			gga_q    <= 1'b0;
			rmc_q    <= 1'b0;
			for (int i = 0; i < FieldSlots; i++) acc_q[i] <= '0;
		end else if (en) begin
			if (clear) begin
				len_q    <= '0;
				dollar_q <= 1'b0;
				fld_q    <= '0;
				recent_q <= '0;
				gga_q    <= 1'b0;
				rmc_q    <= 1'b0;
				for (int i = 0; i < FieldSlots; i++) acc_q[i] <= '0;
			end else if (step) begin
				len_q <= len_q + 1'b1;
				if (!dollar_q) begin
					dollar_q <= (s1_byte == ChDollar);
				end else begin
					if (recent_q == {ChG, ChG} && s1_byte == ChA) gga_q <= 1'b1;
					if (recent_q == {ChR, ChM} && s1_byte == ChC) rmc_q <= 1'b1;
					recent_q <= {recent_q[7:0], s1_byte};
					if (s1_byte == ChComma) begin
						if (fld_q < FldMax) fld_q <= fld_q + 1'b1;
					end else if (fld_q < FldW'(FieldSlots)) begin
						acc_q[fld_q[SlotW-1:0]] <= acc_feed(acc_q[fld_q[SlotW-1:0]], s1_byte);
					end
				end
			end
		end
	end

	assign acc = acc_q;

endmodule

>>> src/ngp_conv.sv
// line-end decode: field selection, coordinate products, altitude and hdop rounding
// depends on ngp_pkg; registers its command into the second stage
module ngp_conv import ngp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ev_t  ev,
	input  acc_t acc [FieldSlots],
	output cmd_t cmd_s2
);

	function automatic logic [6:0] rem_of(input acc_t a);
		return 7'(a.tens) * 7'd10 + 7'(a.ones);
	endfunction

	function automatic logic [31:0] deg_part(input acc_t a);
		logic [7:0] d8;
		d8 = (a.deg > 24'd255) ? 8'd255 : a.deg[7:0];
		return 32'(d8) * 32'd10000000;
	endfunction

	// minutes times 1e7/60, rounded: (min_e5 * 10 + 3) / 6 by reciprocal
	function automatic logic [23:0] min_part(input acc_t a);
		logic [23:0] me5;
		logic [26:0] x;
		logic [56:0] p;
		me5 = 24'(rem_of(a)) * 24'd100000 + 24'(a.frac);
		x   = 27'(me5) * 27'd10 + 27'd3;
		p   = 57'(x) * 57'(Recip6);
		return p[55:32];
	endfunction

	// magnitude in tenths, valid when the integer part is below 100000
	function automatic logic [19:0] tenths_mag(input acc_t a);
		logic [16:0] ip;
		logic [3:0]  r;
		ip = 17'(a.deg[9:0]) * 17'd100 + 17'(rem_of(a));
		r  = 4'd0;
		for (int k = 1; k <= 10; k++) begin
			if (a.frac >= 17'(k * 10000 - 5000)) r = r + 4'd1;
		end
		return 20'(ip) * 20'd10 + 20'(r);
	endfunction

	acc_t lat_a, lon_a;
	logic [7:0] lat_h, lon_h;
	cmd_t cmd;
	logic [19:0] alt_m, hdop_m;
	logic alt_big, hdop_big;
	logic fq_pos, fq_zero, all_pos;

	always_comb begin
		if (ev == EvGga) begin
			lat_a = acc[2];
			lat_h = acc[3].first;
			lon_a = acc[4];
			lon_h = acc[5].first;
		end else begin
			lat_a = acc[3];
			lat_h = acc[4].first;
			lon_a = acc[5];
			lon_h = acc[6].first;
		end

		alt_m    = tenths_mag(acc[9]);
		alt_big  = acc[9].deg >= 24'd1000;
		hdop_m   = tenths_mag(acc[8]);
		hdop_big = acc[8].deg >= 24'd1000;
		fq_zero  = (acc[6].deg == '0) && (acc[6].tens == '0) && (acc[6].ones == '0);
		fq_pos   = !acc[6].neg && !fq_zero;
		all_pos  = acc[2].nonempty && acc[3].nonempty && acc[4].nonempty && acc[5].nonempty;

		cmd          = '0;
		cmd.kind     = ev;
		cmd.lat_degp = deg_part(lat_a);
		cmd.lat_q    = min_part(lat_a);
		cmd.lat_neg  = lat_a.neg ^ (lat_h == ChS || lat_h == ChW);
		cmd.lon_degp = deg_part(lon_a);
		cmd.lon_q    = min_part(lon_a);
		cmd.lon_neg  = lon_a.neg ^ (lon_h == ChS || lon_h == ChW);

		// altitude, saturated to -100000..1000000 tenths
		if (!acc[9].nonempty) begin
			cmd.alt = '0;
		end else if (acc[9].neg) begin
			cmd.alt = (alt_big || alt_m > 20'd100000) ? (21'd0 - 21'd100000)
			                                           : (21'd0 - 21'(alt_m));
		end else begin
			cmd.alt = alt_big ? 21'd1000000 : 21'(alt_m);
		end

		// hdop, saturated to 0..9999
		if (!acc[8].nonempty) begin
			cmd.hdop = 14'd999;
		end else if (acc[8].neg) begin
			cmd.hdop = '0;
		end else begin
			cmd.hdop = (hdop_big || hdop_m > 20'd9999) ? 14'd9999 : hdop_m[13:0];
		end

		cmd.sat = (acc[7].deg != '0) ? 8'd99 : 8'(rem_of(acc[7]));

		unique case (ev)
			EvGga: begin
				cmd.set_sat = acc[7].nonempty && (!acc[7].neg
				              || (acc[7].deg == '0 && acc[7].tens == '0 && acc[7].ones == '0));
				if (acc[6].nonempty) begin
					if (fq_pos) begin
						cmd.set_fix = all_pos;
						cmd.set_pos = all_pos;
						cmd.set_alt = all_pos;
					end else if (fq_zero) begin
						cmd.clr_fix = 1'b1;
					end
				end
			end
			EvRmc: begin
				if (acc[2].nonempty) begin
					if (acc[2].first == ChA && acc[3].nonempty && acc[5].nonempty
					    && acc[4].nonempty && acc[6].nonempty) begin
						cmd.set_fix = 1'b1;
						cmd.set_pos = 1'b1;
					end else if (acc[2].first == ChV) begin
						cmd.clr_fix = 1'b1;
					end
				end
			end
			EvTick, EvNone: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s2 <= '{kind: EvNone, default: '0};
		end else if (en) begin
			cmd_s2 <= cmd;
		end
	end

endmodule

>>> src/ngp_update.sv
// stored position state, update age, freshness and the report word
// depends on ngp_pkg; fed by the command from ngp_conv
module ngp_update import ngp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cmd_t        cmd_s2,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	output logic        push,
	output rep_t        rep
);

	logic [19:0] timeout_q;
	logic        fix_q, ever_q;
	logic [30:0] lat_q;
	logic [31:0] lon_q;
	logic [20:0] alt_q;
	logic [13:0] hdop_q;
	logic [7:0]  sat_q;
	logic [31:0] age_q;

	logic        fix_n, ever_n;
	logic [30:0] lat_n;
	logic [31:0] lon_n;
	logic [20:0] alt_n;
	logic [13:0] hdop_n;
	logic [7:0]  sat_n;
	logic [31:0] age_n;
	logic [31:0] lat_mag, lon_mag, lat_c, lon_c;

	always_comb begin
		lat_mag = cmd_s2.lat_degp + 32'(cmd_s2.lat_q);
		lon_mag = cmd_s2.lon_degp + 32'(cmd_s2.lon_q);
		lat_c   = (lat_mag > LatLim) ? LatLim : lat_mag;
		lon_c   = (lon_mag > LonLim) ? LonLim : lon_mag;

		fix_n  = cmd_s2.set_fix ? 1'b1 : (cmd_s2.clr_fix ? 1'b0 : fix_q);
		lat_n  = cmd_s2.set_pos ? (cmd_s2.lat_neg ? 31'(32'd0 - lat_c) : lat_c[30:0]) : lat_q;
		lon_n  = cmd_s2.set_pos ? (cmd_s2.lon_neg ? (32'd0 - lon_c) : lon_c) : lon_q;
		alt_n  = cmd_s2.set_alt ? cmd_s2.alt : alt_q;
		hdop_n = cmd_s2.set_alt ? cmd_s2.hdop : hdop_q;
		sat_n  = cmd_s2.set_sat ? cmd_s2.sat : sat_q;
		ever_n = ever_q | cmd_s2.set_pos;
		if (cmd_s2.set_pos) begin
			age_n = '0;
		end else if (cmd_s2.kind == EvTick && age_q != '1) begin
			age_n = age_q + 32'd1;
		end else begin
			age_n = age_q;
		end

		push       = en && (cmd_s2.kind != EvNone);
		rep.kind   = cmd_s2.kind;
		rep.fix    = fix_n;
		rep.fresh  = fix_n && ever_n && (age_n <= 32'(timeout_q));
		rep.lat    = lat_n;
		rep.lon    = lon_n;
		rep.alt    = alt_n;
		rep.hdop   = hdop_n;
		rep.sat    = sat_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutRst;
			fix_q     <= 1'b0;
			ever_q    <= 1'b0;
			lat_q     <= '0;
			lon_q     <= '0;
			alt_q     <= '0;
			hdop_q    <= '0;
			sat_q     <= 8'hFF;
			age_q     <= '0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (push) begin
				fix_q  <= fix_n;
				ever_q <= ever_n;
				lat_q  <= lat_n;
				lon_q  <= lon_n;
				alt_q  <= alt_n;
				hdop_q <= hdop_n;
				sat_q  <= sat_n;
				age_q  <= age_n;
			end
		end
	end

endmodule

>>> src/nmea_gga_rmc_position_parser_top.sv
// top level of the nmea gga/rmc position parser: input register, stages, output skid
// depends on ngp_pkg, ngp_line, ngp_conv, ngp_update
//
// One request per cycle on the slave side: s_tuser[0] = 0 carries a received byte in
// s_tdata, s_tuser[0] = 1 is a time tick. A GGA or RMC line closed by CR or LF gives one
// report, a tick always gives one report, other bytes give none. Every report carries
// the stored fix, freshness, position (degrees x 1e7), altitude (dm), hdop (x10) and
// satellite count as they stand after the request. Throughput is one request per
// clock while s_tready is high. The input register takes a request at the accepting
// edge, then the line-end decode register (coordinate products) and the output
// register, which drives m_tvalid, follow. A two-entry output buffer keeps s_tready
// high while one report waits; s_tready drops only when both entries are full.
// Bytes past the 255th of a line are dropped. The user must write fix_timeout_ticks
// via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module nmea_gga_rmc_position_parser_top import ngp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte
	input  logic [0:0]   s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // fix_flag, fix_fresh, latitude, longitude,
	                                // altitude_dm, hdop_tenths, satellites, zero pad
	output logic [1:0]   m_tuser,   // sentence_kind
	input  logic         cfg_we,
	input  logic [19:0]  cfg_wdata  // fix_timeout_ticks
);

	// pipeline up to the output buffer advances unless the skid entry is occupied
	logic en;
	logic s1_valid_s1, s1_op_s1;
	logic [7:0] s1_byte_s1;
	ev_t  ev;
	acc_t acc [FieldSlots];
	cmd_t cmd_s2;
	logic push;
	rep_t rep;
	logic out_valid_q, skid_valid_q;
	rep_t out_q, skid_q;
	logic pop;

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign pop      = out_valid_q && m_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (en) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_op_s1   <= s_tuser[0];
			s1_byte_s1 <= s_tdata;
		end
	end

	ngp_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.s1_valid(s1_valid_s1),
		.s1_op   (s1_op_s1),
		.s1_byte (s1_byte_s1),
		.ev      (ev),
		.acc     (acc)
	);

	ngp_conv u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ev    (ev),
		.acc   (acc),
		.cmd_s2(cmd_s2)
	);

	ngp_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cmd_s2   (cmd_s2),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.rep      (rep)
	);

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_q <= rep;
		end
		if (push && !pop && out_valid_q) begin
			skid_q <= rep;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {4'd0, out_q.sat, out_q.hdop, out_q.alt, out_q.lon, out_q.lat,
	                   out_q.fresh, out_q.fix};

	// the skid entry is only ever filled behind a waiting report
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry holds data while output register is empty");

	// a report that meets a stalled output must land in the skid entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !m_tready) |=> skid_valid_q)
		else $error("report lost against a stalled output");

	// satellite count stays within -1..99
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(out_q.sat) <= 8'sd99 && $signed(out_q.sat) >= -8'sd1))
		else $error("satellite count out of range");

	// hdop saturates at 9999
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.hdop <= 14'd9999))
		else $error("hdop above saturation limit");

endmodule

>>> verif/ngp_scoreboard.sv
// report checker for the nmea gga/rmc position parser testbench
// depends on ngp_pkg; watches the request, report and register ports of the block
`timescale 1ns / 100ps

module ngp_scoreboard import ngp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte
	input  logic [0:0]   s_tuser,   // operation
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,   // fix, fresh, lat, lon, alt, hdop, sats, pad
	input  logic [1:0]   m_tuser,   // sentence_kind
	input  logic         cfg_we,
	input  logic [19:0]  cfg_wdata,
	output int           fail_count,
	output int           pending,
	output int           reports_seen
);

	typedef struct {
		bit               nonempty;
		logic [7:0]       first;
		int               phase;
		bit               neg;
		longint unsigned  ipart;
		int unsigned      frac;
		int               fdig;
	} num_t;

	localparam int unsigned SlotCount = 12;

	int unsigned timeout_ticks;
	int          line_len;
	bit          dollar_seen;
	int          field_no;
	logic [15:0] last_two;
	logic [1:0]  kind_seen;   // bit 0 gga, bit 1 rmc
	num_t        fields [SlotCount];
	bit          fix_held;
	longint      lat_held, lon_held, alt_held, hdop_held, sats_held;
	int unsigned age_ticks;
	bit          ever_set;

	rep_t report_q[$];

	task automatic clear_line();
		line_len    = 0;
		dollar_seen = 0;
		field_no    = 0;
		last_two    = '0;
		kind_seen   = '0;
		foreach (fields[i]) fields[i] = '{0, 8'd0, 0, 0, 0, 0, 0};
	endtask

	task automatic feed_field(input int k, input logic [7:0] c);
		bit digit;
		digit = (c >= Ch0) && (c <= Ch9);
		if (!fields[k].nonempty) begin
			fields[k].nonempty = 1;
			fields[k].first    = c;
		end
		if (fields[k].phase == 0 && (c == ChPlus || c == ChMinus)) begin
			fields[k].neg   = (c == ChMinus);
			fields[k].phase = 1;
		end else if (fields[k].phase <= 1 && digit) begin
			fields[k].phase = 1;
			fields[k].ipart = fields[k].ipart * 10 + (c - Ch0);
			if (fields[k].ipart > 999999999) fields[k].ipart = 999999999;
		end else if (fields[k].phase <= 1 && c == ChDot) begin
			fields[k].phase = 2;
		end else if (fields[k].phase == 2 && digit) begin
			if (fields[k].fdig < 5) begin
				fields[k].frac = fields[k].frac * 10 + (c - Ch0);
				fields[k].fdig++;
			end
		end else begin
			fields[k].phase = 3;
		end
	endtask

	// fraction scaled to five decimal places
	function automatic longint unsigned frac_e5(input num_t a);
		longint unsigned f;
		f = a.frac;
		for (int i = a.fdig; i < 5; i++) f = f * 10;
		return f;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint to_tenths(input num_t a);
		longint m;
		m = longint'((a.ipart * 100000 + frac_e5(a) + 5000) / 10000);
		return a.neg ? -m : m;
	endfunction

	// ddmm.mmmmm to degrees x 1e7, minutes rounded to nearest
	function automatic longint to_coord(input num_t a, input logic [7:0] hemi,
			input longint lim);
		longint unsigned degs, mins;
		longint          v;
		degs = a.ipart / 100;
		mins = (a.ipart % 100) * 100000 + frac_e5(a);
		v    = longint'(degs * 10000000 + (mins * 10 + 3) / 6);
		if (a.neg) v = -v;
		if (hemi == ChS || hemi == ChW) v = -v;
		return clamp(v, -lim, lim);
	endfunction

	task automatic mark_fresh();
		age_ticks = 0;
		ever_set  = 1;
	endtask

	task automatic apply_gga();
		if (fields[7].nonempty && (!fields[7].neg || fields[7].ipart == 0))
			sats_held = fields[7].ipart > 99 ? 99 : longint'(fields[7].ipart);
		if (!fields[6].nonempty) return;
		if (!fields[6].neg && fields[6].ipart > 0) begin
			if (fields[2].nonempty && fields[3].nonempty && fields[4].nonempty
					&& fields[5].nonempty) begin
				fix_held  = 1;
				lat_held  = to_coord(fields[2], fields[3].first, 900000000);
				lon_held  = to_coord(fields[4], fields[5].first, 1800000000);
				alt_held  = fields[9].nonempty ? clamp(to_tenths(fields[9]), -100000, 1000000) : 0;
				hdop_held = fields[8].nonempty ? clamp(to_tenths(fields[8]), 0, 9999) : 999;
				mark_fresh();
			end
		end else if (fields[6].ipart == 0) begin
			fix_held = 0;
		end
	endtask

	task automatic apply_rmc();
		if (!fields[2].nonempty) return;
		if (fields[2].first == ChA && fields[3].nonempty && fields[4].nonempty
				&& fields[5].nonempty && fields[6].nonempty) begin
			fix_held = 1;
			lat_held = to_coord(fields[3], fields[4].first, 900000000);
			lon_held = to_coord(fields[5], fields[6].first, 1800000000);
			mark_fresh();
		end else if (fields[2].first == ChV) begin
			fix_held = 0;
		end
	endtask

	task automatic queue_report(input ev_t kind);
		rep_t r;
		r.kind  = kind;
		r.fix   = fix_held;
		r.fresh = fix_held && ever_set && age_ticks <= timeout_ticks;
		r.lat   = 31'(lat_held);
		r.lon   = 32'(lon_held);
		r.alt   = 21'(alt_held);
		r.hdop  = 14'(hdop_held);
		r.sat   = 8'(sats_held);
		report_q.push_back(r);
	endtask

	task automatic take_request(input bit is_tick, input logic [7:0] c);
		if (is_tick) begin
			if (age_ticks != 32'hFFFF_FFFF) age_ticks++;
			queue_report(EvTick);
			return;
		end
		if (c == ChLf || c == ChCr) begin
			if (line_len == 0) return;
			if (dollar_seen && kind_seen[0]) begin
				apply_gga();
				queue_report(EvGga);
			end else if (dollar_seen && kind_seen[1]) begin
				apply_rmc();
				queue_report(EvRmc);
			end
			clear_line();
			return;
		end
		if (line_len >= LineBytes - 1) return;
		line_len++;
		if (!dollar_seen) begin
			if (c == ChDollar) dollar_seen = 1;
			return;
		end
		if (last_two == {ChG, ChG} && c == ChA) kind_seen[0] = 1;
		if (last_two == {ChR, ChM} && c == ChC) kind_seen[1] = 1;
		last_two = {last_two[7:0], c};
		if (c == ChComma) begin
			if (field_no < 31) field_no++;
		end else if (field_no < SlotCount) begin
			feed_field(field_no, c);
		end
	endtask

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		if (fail_count < 10)
			$display("%0t report mismatch in %s: expected %0d, got %0d", $realtime, what,
				want, got);
		fail_count++;
	endtask

	task automatic check_report(input rep_t got);
		rep_t want;
		if (report_q.size() == 0) begin
			if (fail_count < 10) $display("%0t unexpected report, kind %0d", $realtime, got.kind);
			fail_count++;
			return;
		end
		want = report_q.pop_front();
		if (got.kind != want.kind) flag_mismatch("sentence_kind", want.kind, got.kind);
		if (got.fix != want.fix) flag_mismatch("fix_flag", want.fix, got.fix);
		if (got.fresh != want.fresh) flag_mismatch("fix_fresh", want.fresh, got.fresh);
		if (got.lat != want.lat) flag_mismatch("latitude", $signed(want.lat), $signed(got.lat));
		if (got.lon != want.lon) flag_mismatch("longitude", $signed(want.lon), $signed(got.lon));
		if (got.alt != want.alt) flag_mismatch("altitude_dm", $signed(want.alt), $signed(got.alt));
		if (got.hdop != want.hdop) flag_mismatch("hdop_tenths", want.hdop, got.hdop);
		if (got.sat != want.sat) flag_mismatch("satellites", $signed(want.sat), $signed(got.sat));
	endtask

	initial begin
		fail_count   = 0;
		reports_seen = 0;
		pending      = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rep_t got;
		if (!arst_n) begin
			timeout_ticks = TimeoutRst;
			clear_line();
			fix_held  = 0;
			lat_held  = 0;
			lon_held  = 0;
			alt_held  = 0;
			hdop_held = 0;
			sats_held = -1;
			age_ticks = 0;
			ever_set  = 0;
			report_q.delete();
		end else begin
			if (cfg_we) timeout_ticks = cfg_wdata;
			if (s_tvalid && s_tready) take_request(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser;
				got.fix   = m_tdata[0];
				got.fresh = m_tdata[1];
				got.lat   = m_tdata[32:2];
				got.lon   = m_tdata[64:33];
				got.alt   = m_tdata[85:65];
				got.hdop  = m_tdata[99:86];
				got.sat   = m_tdata[107:100];
				reports_seen++;
				check_report(got);
			end
		end
		pending = report_q.size();
	end

endmodule

>>> verif/tb_nmea_gga_rmc_position_parser_top.sv
// testbench top for the nmea gga/rmc position parser: sentence stimulus and verdict
// depends on ngp_pkg, nmea_gga_rmc_position_parser_top and ngp_scoreboard
`timescale 1ns / 100ps

module tb_nmea_gga_rmc_position_parser_top;
	import ngp_pkg::*;

	localparam int CycleLimit = 2000000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic [19:0]  cfg_wdata;

	int fail_count, pending, reports_seen;
	int bytes_sent, ticks_sent, lines_sent;
	int cycles;
	bit calm;       // when set, neither side inserts gaps
	bit rd_took;
	int rd_stall;

	nmea_gga_rmc_position_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ngp_scoreboard u_scoreboard (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// report side: random stall drawn for every report taken
	always @(posedge clk) rd_took <= m_tvalid && m_tready;

	always @(negedge clk) begin
		if (rd_took) rd_stall = calm ? 0 : $urandom_range(0, 14);
		if (rd_stall > 0) begin
			m_tready <= 1'b0;
			rd_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one request; entered and left at a falling edge, valid stays high afterward
	task automatic push(input bit is_tick, input logic [7:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_tick;
		s_tdata  <= d;
		#1;
		while (!s_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		if (is_tick) ticks_sent++;
		else bytes_sent++;
	endtask

	task automatic send_tick();
		push(1'b1, 8'd0);
	endtask

	// sends the text, then a random line ending (cr, lf or both)
	task automatic send_line(input string text);
		int sel;
		foreach (text[i]) push(1'b0, text[i]);
		sel = $urandom_range(0, 2);
		if (sel != 1) push(1'b0, ChCr);
		if (sel != 0) push(1'b0, ChLf);
		lines_sent++;
	endtask

	// block idle: nothing expected, plus the pipeline depth for lines with no report
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [19:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random number text: mostly plain values, sometimes signs, junk or long digit runs
	function automatic string rand_number(input int unsigned hi);
		case ($urandom_range(0, 9))
			0:       return "";
			1:       return $sformatf("-%0d.%0d", $urandom_range(0, hi), $urandom_range(0, 99));
			2:       return $sformatf("+%0d", $urandom_range(0, hi));
			3:       return "1234567890123.1234567";
			4:       return $sformatf("%0dx%0d", $urandom_range(0, hi), $urandom_range(0, 9));
			5:       return $sformatf("%0d.", $urandom_range(0, hi));
			default: return $sformatf("%0d.%0d", $urandom_range(0, hi), $urandom_range(0, 999));
		endcase
	endfunction

	function automatic string rand_coord(input int unsigned deg_hi);
		if ($urandom_range(0, 9) == 0) return rand_number(99999);
		return $sformatf("%0d%02d.%05d", $urandom_range(0, deg_hi), $urandom_range(0, 59),
			$urandom_range(0, 99999));
	endfunction

	function automatic string rand_hemi(input string pos, input string neg_s);
		case ($urandom_range(0, 6))
			0:       return "";
			1:       return "Q";
			2, 3:    return neg_s;
			default: return pos;
		endcase
	endfunction

	function automatic string rand_talker();
		case ($urandom_range(0, 3))
			0:       return "GN";
			1:       return "x$GP";
			default: return "GP";
		endcase
	endfunction

	function automatic string rand_gga();
		string q;
		q = ($urandom_range(0, 3) == 0) ? rand_number(9) : $sformatf("%0d", $urandom_range(0, 2));
		return $sformatf("$%sGGA,%06d.00,%s,%s,%s,%s,%s,%s,%s,%s,M,,,*5A", rand_talker(),
			$urandom_range(0, 235959), rand_coord(99), rand_hemi("N", "S"), rand_coord(199),
			rand_hemi("E", "W"), q, rand_number(150), rand_number(1200),
			rand_number(120000));
	endfunction

	function automatic string rand_rmc();
		string st;
		case ($urandom_range(0, 4))
			0:       st = "V";
			1:       st = ($urandom_range(0, 1) != 0) ? "" : "X";
			default: st = "A";
		endcase
		return $sformatf("$%sRMC,%06d.00,%s,%s,%s,%s,%s,0.5,54.7,191194,,*3C", rand_talker(),
			$urandom_range(0, 235959), st, rand_coord(99), rand_hemi("N", "S"),
			rand_coord(199), rand_hemi("E", "W"));
	endfunction

	// noise: random bytes of any value, occasionally broken sentence fragments
	function automatic string rand_noise();
		string s;
		int n;
		s = "";
		n = $urandom_range(1, 30);
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
		if ($urandom_range(0, 1) != 0) s = {"$GPRM", s};
		return s;
	endfunction

	task automatic directed_part();
		string longline;
		string head;
		send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
		send_tick();
		send_line("$GPRMC,123519,A,4807.038,S,01131.000,W,022.4,084.4,230394,003.1,W*6A");
		send_line("$GPRMC,123520,V,,,,,,,,,*00");
		// empty fields counted, hdop absent gives 99.9 and altitude 0
		send_line("$GPGGA,,9000.00000,N,18000.00000,E,2,,,,M,,M,,");
		// saturation of altitude, hdop and satellites; beyond-limit coordinates
		send_line("$GPGGA,1,9959.99999,S,99959.99999,W,6,150,9999.96,99999.99,M");
		send_line("$GPGGA,1,-0000.00001,N,-1.5,E,1,-3,-5,-99999.95,M");
		send_line("$GPGGA,1,0,N,0,E,0,00,,,M");   // fix quality zero clears the fix
		send_line("$GPGGA,1,2,N,3,E,-2,-0,1,1,M"); // negative quality, zero count
		send_line("GPGGA,no dollar here");
		send_line("$GPGSV,3,1,11*70");             // neither type
		send_line("");                             // bare line ending
		send_line("$GPRMC GGA,1,A,5,N,6,E");      // both types: gga wins
		// a zero byte inside the altitude field stops the number there
		head = "$GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,5";
		foreach (head[i]) push(1'b0, head[i]);
		push(1'b0, 8'h00);
		send_line(".4,M");
		longline = "$GPRMC,1,A,1234.5,N,12345.6,E";
		for (int i = 0; i < 250; i++) longline = {longline, "9"};
		send_line(longline);                       // bytes beyond 255 dropped
		send_line({"$GP", string'(8'hFF), "RMC,1,A,1.0,N,2.0,W"});
		repeat (3) send_tick();
	endtask

	task automatic random_part(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0) calm = ~calm;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_line(rand_gga());
				4, 5, 6:    send_line(rand_rmc());
				7:          send_line(rand_noise());
				default:    repeat ($urandom_range(1, 6)) send_tick();
			endcase
		end
		calm = 0;
	endtask

	initial begin
		logic [19:0] timeouts [5];
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		calm      = 0;
		rd_took   = 0;
		rd_stall  = 0;
		cycles    = 0;
		bytes_sent = 0;
		ticks_sent = 0;
		lines_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// low timeout makes ticks expire freshness quickly; extremes and a random setting
		timeouts = '{20'd1000000, 20'd1, 20'd3, 20'($urandom_range(1, 20)), 20'hFFFFF};
		directed_part();
		foreach (timeouts[i]) begin
			drain();
			write_timeout(timeouts[i] == 20'hFFFFF ? 20'd1000000 - 20'($urandom_range(0, 3))
				: timeouts[i]);
			if (i == 1) write_timeout(20'hAAAAA ^ 20'($urandom));
			if (i == 1) write_timeout(20'd1);
			random_part(220);
		end
		drain();

		$display("covered %0d bytes in %0d lines, %0d ticks, %0d reports checked",
			bytes_sent, lines_sent, ticks_sent, reports_seen);
		$display("timeout register taken through 1, 3, small random and 1000000 settings");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d reports still expected", fail_count, pending);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
